/* rtl/assert_macros.svh */
// Assertion helpers for clocked checks with synchronous active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/iis_pkg.sv */
package iis_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int SUM_WIDTH   = 8;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 12;
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 13;
  localparam int PIX_W       = 8;
  localparam int OUT_W       = 8;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 13;
  localparam int HEIGHT_MAX  = 4096;
  localparam int WCMP_W      = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
  localparam int HCMP_W      = (ROW_W + 1 > HEIGHT_W) ? ROW_W + 1 : HEIGHT_W;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_COLS = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_ROWS = CFG_ADDR_W'(1);

  typedef logic [SUM_WIDTH-1:0] sum_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             col_zero;
    logic             first_row;
    logic             row_end;
    logic             frame_end;
  } pos_t;

  typedef struct packed {
    logic             we;
    logic [COL_W-1:0] addr;
    sum_t             data;
  } store_wr_t;

endpackage

/* rtl/iis_ctrl.sv */
module iis_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [iis_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [iis_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           take,
  output iis_pkg::pos_t                  pos
);
  import iis_pkg::*;

  logic [WIDTH_W-1:0]  frame_cols_r;
  logic [HEIGHT_W-1:0] frame_rows_r;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [WCMP_W-1:0]   width_act, width_ext, col_inc;
  logic [HCMP_W-1:0]   height_act, height_ext, row_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cols_r <= WIDTH_W'(1024);
      frame_rows_r <= HEIGHT_W'(1024);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_COLS: frame_cols_r <= cfg_wdata[WIDTH_W-1:0];
        REG_FRAME_ROWS: frame_rows_r <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    width_ext = WCMP_W'(frame_cols_r);
    if (width_ext == '0) begin
      width_act = WCMP_W'(1);
    end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
      width_act = WCMP_W'(MAX_WIDTH);
    end else begin
      width_act = width_ext;
    end
    height_ext = HCMP_W'(frame_rows_r);
    if (height_ext == '0) begin
      height_act = HCMP_W'(1);
    end else if (height_ext > HCMP_W'(HEIGHT_MAX)) begin
      height_act = HCMP_W'(HEIGHT_MAX);
    end else begin
      height_act = height_ext;
    end
    col_inc = WCMP_W'(col_r) + WCMP_W'(1);
    row_inc = HCMP_W'(row_r) + HCMP_W'(1);

    pos.col       = col_r;
    pos.col_zero  = (col_r == '0);
    pos.first_row = (row_r == '0);
    pos.row_end   = (col_inc >= width_act);
    pos.frame_end = pos.row_end && (row_inc >= height_act);

    col_nxt = col_r;
    row_nxt = row_r;
    if (take) begin
      if (pos.row_end) begin
        col_nxt = '0;
        row_nxt = pos.frame_end ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* rtl/iis_line_store.sv */
module iis_line_store (
  input  logic                      clk,
  input  iis_pkg::store_wr_t        wr,
  input  logic                      re,
  input  logic [iis_pkg::COL_W-1:0] raddr,
  output iis_pkg::sum_t             rdata
);
  import iis_pkg::*;

  sum_t mem [MAX_WIDTH];
  sum_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // A read that hits the entry being written in the same cycle returns the new value.
  always_ff @(posedge clk) begin
    if (re) begin
      if (wr.we && (wr.addr == raddr)) begin
        rdata_r <= wr.data;
      end else begin
        rdata_r <= mem[raddr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/iis_accum.sv */
module iis_accum (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      take,
  input  logic [iis_pkg::PIX_W-1:0] pixel,
  input  iis_pkg::pos_t             pos,
  input  iis_pkg::sum_t             above_raw,
  input  logic                      out_tready,
  output logic                      s1_free,
  output iis_pkg::store_wr_t        wr,
  output logic                      out_tvalid,
  output logic [iis_pkg::OUT_W-1:0] out_value,
  output logic                      out_last
);
  import iis_pkg::*;

  logic                 s1_valid_r;
  logic [PIX_W-1:0]     pix_r;
  pos_t                 pos_r;
  sum_t                 acc_r, acc_nxt;
  sum_t                 value;
  logic                 advance;
  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_value_r;
  logic                 out_last_r;

  assign advance = s1_valid_r && (!out_valid_r || out_tready);
  assign s1_free = !s1_valid_r || advance;

  always_comb begin
    sum_t row_sum;
    sum_t above;
    row_sum = pos_r.col_zero ? SUM_WIDTH'(pix_r) : acc_r + SUM_WIDTH'(pix_r);
    above   = pos_r.first_row ? '0 : above_raw;
    value   = row_sum + above;
    acc_nxt = acc_r;
    if (advance) begin
      acc_nxt = pos_r.row_end ? '0 : row_sum;
    end
    wr.we   = advance;
    wr.addr = pos_r.col;
    wr.data = value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      acc_r <= acc_nxt;
      if (take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pix_r <= pixel;
      pos_r <= pos;
    end
    if (advance) begin
      out_value_r <= value[OUT_W-1:0];
      out_last_r  <= pos_r.frame_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

endmodule

/* rtl/integral_image_stream_top.sv */
// Channel   Direction  Payload
// in_       slave      tdata[7:0] pixel_value
// out_      master     tdata[7:0] integral_value, tlast last_of_frame
// cfg_      write      addr 0 row length, addr 1 rows per frame
//
// One item is accepted every cycle while the output is not stalled; each result is registered
// in the input stage, whose line store read is issued at acceptance, then in the output register.
// Reset is synchronous and active low; it clears the position, the row sum and the
// valid flags, while the line store keeps its contents and needs no clearing pass.
// A stalled output holds its item; the input keeps flowing until the one stage behind it fills.
`include "assert_macros.svh"

module integral_image_stream_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] pixel_value
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] integral_value
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [iis_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [iis_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import iis_pkg::*;

  pos_t      pos;
  store_wr_t wr;
  sum_t      above_raw;
  logic      s1_free;
  logic      take;

  assign in_tready = s1_free;
  assign take      = in_tvalid && s1_free;

  iis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .pos       (pos)
  );

  iis_line_store u_store (
    .clk   (clk),
    .wr    (wr),
    .re    (take),
    .raddr (pos.col),
    .rdata (above_raw)
  );

  iis_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .pixel      (in_tdata[PIX_W-1:0]),
    .pos        (pos),
    .above_raw  (above_raw),
    .out_tready (out_tready),
    .s1_free    (s1_free),
    .wr         (wr),
    .out_tvalid (out_tvalid),
    .out_value  (out_tdata),
    .out_last   (out_tlast)
  );

  `ASSERT_NEXT(a_frame_wrap, take && pos.frame_end, pos.col_zero && pos.first_row)
  `ASSERT_NEXT(a_row_wrap, take && pos.row_end && !pos.frame_end, pos.col_zero && !pos.first_row)
  `ASSERT_NEXT(a_col_step, take && !pos.row_end, pos.col == $past(pos.col) + COL_W'(1))
  `ASSERT_SAME(a_frame_end_is_row_end, pos.frame_end, pos.row_end)

endmodule
